### src/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, constants, sequencer steps and microcode table for the
// Newton-Raphson square root unit.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int RAD_W          = 32;
    localparam int ROOT_W         = 24;
    localparam int TOL_W          = 8;
    localparam int FRAC_W         = 16;
    localparam int WIDE_W         = RAD_W + FRAC_W;
    localparam int DIV_CNT_W      = $clog2(WIDE_W);
    localparam int MAX_ITERATIONS = 32;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS);

    localparam logic [RAD_W-1:0]  ONE_Q16  = RAD_W'(32'h0001_0000);
    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;
    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WIDE_W - 1);
    localparam logic [ITER_W-1:0]    ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_UPDATE,
        ST_OUT
    } t_step;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_INIT,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_SPECIAL,
        C_DIV_MORE,
        C_CONTINUE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        unique case (pc)
            ST_IDLE:     w = '{op: OP_CAPTURE,  cond: C_NO_START, target: ST_IDLE};
            ST_INIT:     w = '{op: OP_INIT,     cond: C_SPECIAL,  target: ST_OUT};
            ST_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: C_NEVER,    target: ST_IDLE};
            ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: ST_DIV_STEP};
            ST_UPDATE:   w = '{op: OP_UPDATE,   cond: C_CONTINUE, target: ST_DIV_LOAD};
            ST_OUT:      w = '{op: OP_OUT,      cond: C_ALWAYS,   target: ST_IDLE};
            default:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/nsr_divider.sv
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring bit-serial unsigned divider, one quotient bit per cycle while step is asserted.
// ----------------------------------------------------------------------------
module nsr_divider
    import nsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctrl         i_ctrl,
    input  logic [WIDE_W-1:0] i_dividend,
    input  logic [WIDE_W-1:0] i_divisor,
    output logic [WIDE_W-1:0] o_quotient,
    output logic              o_last
);

    logic [WIDE_W-1:0]    r_rem, n_rem;
    logic [WIDE_W-1:0]    r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WIDE_W:0]      shifted;
    logic [WIDE_W:0]      trial;

    always_comb begin
        shifted = {r_rem, r_quo[WIDE_W-1]};
        trial   = shifted - {1'b0, i_divisor};
        if (!trial[WIDE_W]) begin
            n_rem = trial[WIDE_W-1:0];
            n_quo = {r_quo[WIDE_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[WIDE_W-1:0];
            n_quo = {r_quo[WIDE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.load) begin
            r_cnt <= '0;
        end else if (i_ctrl.step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_ctrl.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = (r_cnt == DIV_LAST);

endmodule

### src/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// Q16.16 square root by Newton-Raphson, run by a microcoded sequencer.
// After acceptance, zero or one goes from the init step straight to the output
// step, which raises o_valid; other radicands run N Newton steps, each of one
// load, a bit-serial divide and one update, with N at most 32. One request at a
// time: busy is high from acceptance until the o_valid cycle ends; the receiver
// cannot stall.
// Synchronous active-low reset idles the sequencer and sets tolerance to 1.
// ----------------------------------------------------------------------------
module newton_square_root
    import nsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RAD_W-1:0]  i_radicand,
    input  logic              i_tol_we,
    input  logic [TOL_W-1:0]  i_tolerance,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_limit_reached
);

    t_step             r_pc, n_pc;
    t_uword            uw;
    logic              cond_true;
    logic [TOL_W-1:0]  r_tol;
    logic [RAD_W-1:0]  r_rad;
    logic [WIDE_W-1:0] r_guess;
    logic [ITER_W-1:0] r_iter;
    logic              r_flag;
    logic              special;
    logic [RAD_W-1:0]  half_rad;
    logic [WIDE_W:0]   sum;
    logic [WIDE_W-1:0] nxt;
    logic [WIDE_W-1:0] diff;
    logic              converged;
    t_div_ctrl         div_ctrl;
    logic [WIDE_W-1:0] quotient;
    logic              div_last;

    assign uw = ucode(r_pc);

    // datapath terms
    assign special   = (r_rad == '0) || (r_rad == ONE_Q16);
    assign half_rad  = (r_rad >> 1) == '0 ? RAD_W'(1) : (r_rad >> 1);
    assign sum       = {1'b0, r_guess} + {1'b0, quotient};
    assign nxt       = sum[WIDE_W:1] == '0 ? WIDE_W'(1) : sum[WIDE_W:1];
    assign diff      = (nxt > r_guess) ? (nxt - r_guess) : (r_guess - nxt);
    assign converged = diff <= {{(WIDE_W-TOL_W){1'b0}}, r_tol};

    // jump condition
    always_comb begin
        unique case (uw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_START: cond_true = !start;
            C_SPECIAL:  cond_true = special;
            C_DIV_MORE: cond_true = !div_last;
            C_CONTINUE: cond_true = !converged && (r_iter != ITER_LAST);
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = cond_true ? uw.target : t_step'(r_pc + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tolerance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
            r_flag <= 1'b0;
        end else begin
            case (uw.op)
                OP_INIT: begin
                    r_iter <= '0;
                    r_flag <= 1'b0;
                end
                OP_UPDATE: begin
                    r_iter <= r_iter + ITER_W'(1);
                    r_flag <= !converged;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_CAPTURE: r_rad <= i_radicand;
            OP_INIT:    r_guess <= special ? WIDE_W'(r_rad) : WIDE_W'(half_rad);
            OP_UPDATE:  r_guess <= nxt;
            default: ;
        endcase
    end

    always_comb begin
        div_ctrl.load = (uw.op == OP_DIV_LOAD);
        div_ctrl.step = (uw.op == OP_DIV_STEP);
    end

    nsr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend ({r_rad, {FRAC_W{1'b0}}}),
        .i_divisor  (r_guess),
        .o_quotient (quotient),
        .o_last     (div_last)
    );

    assign busy            = (r_pc != ST_IDLE);
    assign o_valid         = (uw.op == OP_OUT);
    assign o_root          = (r_guess > WIDE_W'(ROOT_MAX)) ? ROOT_MAX : r_guess[ROOT_W-1:0];
    assign o_limit_reached = r_flag;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("result strobe not followed by idle");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_DIV_STEP) |-> (r_guess != '0))
        else $error("divide by zero guess");

    a_converge_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_UPDATE) && converged |=> (r_pc == ST_OUT) && !r_flag)
        else $error("converged step did not finish");

    a_limit_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_limit_reached |-> (r_iter == '0))
        else $error("limit flag without full iteration count");

endmodule

### tb/tb_newton_square_root.sv
// ----------------------------------------------------------------------------
// tb_newton_square_root
// Self-checking bench for the Q16.16 Newton-Raphson square root unit. Every
// request sent is run through a local copy of the iteration, using the
// tolerance last written, and each strobed root is compared with the oldest
// outstanding prediction. Corner radicands come first, then a tolerance-zero
// set, then random requests under several tolerances and sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_newton_square_root;
    import nsr_pkg::*;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic              limit_hit;
    } t_sqrt_expect;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [RAD_W-1:0]  i_radicand = '0;
    logic              i_tol_we = 1'b0;
    logic [TOL_W-1:0]  i_tolerance = '0;
    logic              o_valid;
    logic [ROOT_W-1:0] o_root;
    logic              o_limit_reached;

    t_sqrt_expect      pending_roots[$];
    logic [TOL_W-1:0]  tol_setting = TOL_RESET;
    int                idle_pct = 0;
    int                error_count = 0;

    newton_square_root u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_radicand     (i_radicand),
        .i_tol_we       (i_tol_we),
        .i_tolerance    (i_tolerance),
        .o_valid        (o_valid),
        .o_root         (o_root),
        .o_limit_reached(o_limit_reached)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #150_000_000;
        $display("tb_newton_square_root NOT OK");
        $finish;
    end

    function automatic t_sqrt_expect newton_root(input logic [RAD_W-1:0] rad,
                                                 input logic [TOL_W-1:0] tol);
        t_sqrt_expect res;
        logic [63:0]  guess;
        logic [63:0]  quo;
        logic [63:0]  nxt;
        logic [63:0]  gap;
        res.rad = rad;
        if (rad == '0 || rad == ONE_Q16) begin
            res.root = rad[ROOT_W-1:0];
            res.limit_hit = 1'b0;
            return res;
        end
        guess = 64'(rad >> 1);
        if (guess == 64'd0) guess = 64'd1;
        res.limit_hit = 1'b1;
        for (int k = 0; k < MAX_ITERATIONS; k++) begin
            quo = (64'(rad) << FRAC_W) / guess;
            nxt = (guess + quo) >> 1;
            if (nxt == 64'd0) nxt = 64'd1;
            gap = (nxt > guess) ? nxt - guess : guess - nxt;
            guess = nxt;
            if (gap <= 64'(tol)) begin
                res.limit_hit = 1'b0;
                break;
            end
        end
        res.root = (guess > 64'(ROOT_MAX)) ? ROOT_MAX : guess[ROOT_W-1:0];
        return res;
    endfunction

    function automatic logic [RAD_W-1:0] pick_radicand();
        logic [RAD_W-1:0] v;
        case ($urandom_range(9))
            0:       v = ONE_Q16 + RAD_W'($urandom_range(8)) - RAD_W'(4);
            1:       v = RAD_W'($urandom_range(3));
            2:       v = '1 - RAD_W'($urandom_range(3));
            default: v = $urandom >> $urandom_range(31);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        error_count++;
    endtask

    task automatic send_radicand(input logic [RAD_W-1:0] rad);
        logic accepted;
        accepted = 1'b0;
        i_radicand <= rad;
        while (!accepted) begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
            accepted = start && !busy;
        end
        pending_roots.push_back(newton_root(rad, tol_setting));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_roots.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        wait_drained();
        i_tol_we <= 1'b1;
        i_tolerance <= tol;
        @(posedge i_clk);
        i_tol_we <= 1'b0;
        tol_setting = tol;
    endtask

    // results are strobed for one cycle; nothing can hold them off
    always @(posedge i_clk) begin
        t_sqrt_expect exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%h limit=%b",
                                          o_root, o_limit_reached));
            end else begin
                exp_res = pending_roots.pop_front();
                if (o_root !== exp_res.root)
                    report_mismatch($sformatf("rad=%h root=%h expected %h",
                                              exp_res.rad, o_root, exp_res.root));
                if (o_limit_reached !== exp_res.limit_hit)
                    report_mismatch($sformatf("rad=%h limit_reached=%b expected %b",
                                              exp_res.rad, o_limit_reached,
                                              exp_res.limit_hit));
            end
        end
    end

    task automatic test_corners();
        logic [RAD_W-1:0] corner_vals [16] = '{
            32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
            32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h0004_0000,
            32'h0009_0000, 32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
        };
        idle_pct = 0;
        foreach (corner_vals[k]) send_radicand(corner_vals[k]);
    endtask

    // tolerance zero lets integer Newton bounce between neighbors up to the cap
    task automatic test_tolerance_zero();
        logic [RAD_W-1:0] osc_vals [6] = '{
            32'h0002_0000, 32'h0003_0000, 32'h0000_0003,
            32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0002
        };
        write_tolerance('0);
        foreach (osc_vals[k]) send_radicand(osc_vals[k]);
    endtask

    task automatic test_random_phase(input logic [TOL_W-1:0] tol, input int idle,
                                     input int count);
        write_tolerance(tol);
        idle_pct = idle;
        repeat (count) send_radicand(pick_radicand());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_tolerance_zero();
        test_random_phase(TOL_W'($urandom_range(2, 254)), 0, 250);
        test_random_phase('0, 50, 250);
        test_random_phase('1, 35, 250);
        test_random_phase(TOL_W'($urandom_range(1, 16)), 50, 250);

        wait_drained();
        repeat (1700) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_newton_square_root OK");
        end else begin
            $display("tb_newton_square_root NOT OK");
        end
        $finish;
    end

endmodule
